// ===== src/pbm_pkg.sv =====
// Shared types and constants for the pixel blend pipeline.
package pbm_pkg;

  typedef enum logic [1:0] {
    MODE_MULTIPLY = 2'd0,
    MODE_SUBTRACT = 2'd1,
    MODE_SCREEN   = 2'd2,
    MODE_OVERLAY  = 2'd3
  } blend_mode_t;

  localparam int unsigned NUM_CHAN = 3;

  // Rounding offset and reciprocal of 255 for a 16-bit dividend.
  localparam logic [15:0] ROUND_OFS  = 16'd127;
  localparam logic [15:0] RECIP_255  = 16'd32897;
  localparam int unsigned RECIP_SHIFT = 23;

  typedef logic [7:0] chan_t;

  // One channel's operands after mode decode.
  typedef struct packed {
    chan_t x;
    chan_t y;
    logic  inv;
    logic  sub;
    chan_t sub_res;
  } chan_op_t;

  // One channel after the first multiply.
  typedef struct packed {
    logic [15:0] prod;
    logic        inv;
    logic        sub;
    chan_t       sub_res;
  } chan_prod_t;

  // One channel after the reciprocal multiply.
  typedef struct packed {
    chan_t q;
    logic  inv;
    logic  sub;
    chan_t sub_res;
  } chan_quot_t;

endpackage

// ===== src/pbm_pix_in_if.sv =====
// Input channel: base and layer pixel words.
interface pbm_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_blue;
  logic [7:0] base_green;
  logic [7:0] base_red;
  logic [7:0] layer_blue;
  logic [7:0] layer_green;
  logic [7:0] layer_red;
  logic       pixel_last;

  modport source (
    output valid, base_blue, base_green, base_red,
    output layer_blue, layer_green, layer_red, pixel_last,
    input  ready
  );
  modport sink (
    input  valid, base_blue, base_green, base_red,
    input  layer_blue, layer_green, layer_red, pixel_last,
    output ready
  );
endinterface

// ===== src/pbm_pix_out_if.sv =====
// Output channel: blended pixel words.
interface pbm_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic       out_last;

  modport source (
    output valid, out_blue, out_green, out_red, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_blue, out_green, out_red, out_last,
    output ready
  );
endinterface

// ===== src/pbm_cfg_if.sv =====
// Configuration write channel: blend mode word.
interface pbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/pixel_blend_modes.sv =====
// Pixel blend pipeline: multiply, subtract, screen and overlay per channel.
//
// Usage:
//   pix_in carries one base pixel and one layer pixel (blue, green, red) per
//   word plus an end-of-image mark; pix_out returns one blended pixel per
//   word with the mark copied. cfg writes the 2-bit blend mode, which applies
//   to every pixel; write it only while no pixel is in flight. cfg is always
//   ready.
//   A word accepted on pix_in passes through four register stages (operand
//   decode, channel multiply, reciprocal multiply for the divide by 255,
//   output register) before it shows on pix_out. Throughput: one pixel per
//   clock while pix_out is ready, set by the fully pipelined multipliers.
//   Reset clears all stage valid bits and sets the mode to multiply.
//   When pix_out stalls, each stage holds while the stage after it is full
//   and held; pix_in.ready drops only when all four stages are full.
module pixel_blend_modes (
  input  logic             clk,
  input  logic             rst,
  pbm_pix_in_if.sink       pix_in,
  pbm_pix_out_if.source    pix_out,
  pbm_cfg_if.sink          cfg
);
  import pbm_pkg::*;

  localparam int unsigned NUM_STAGES = 4;

  blend_mode_t blend_mode;

  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] en;

  chan_op_t   s1_op   [NUM_CHAN];
  chan_prod_t s2_prod [NUM_CHAN];
  chan_quot_t s3_quot [NUM_CHAN];
  chan_t      s4_res  [NUM_CHAN];
  logic [NUM_STAGES-1:0] last;

  chan_t    base_ch  [NUM_CHAN];
  chan_t    layer_ch [NUM_CHAN];
  chan_op_t op_next  [NUM_CHAN];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_MULTIPLY;
    end else if (cfg.valid) begin
      blend_mode <= blend_mode_t'(cfg.data);
    end
  end

  // Stage enables: load when empty or when the next stage loads.
  always_comb begin
    en[NUM_STAGES-1] = !v[NUM_STAGES-1] || pix_out.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign pix_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= pix_in.valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  assign base_ch[0]  = pix_in.base_blue;
  assign base_ch[1]  = pix_in.base_green;
  assign base_ch[2]  = pix_in.base_red;
  assign layer_ch[0] = pix_in.layer_blue;
  assign layer_ch[1] = pix_in.layer_green;
  assign layer_ch[2] = pix_in.layer_red;

  // Decode the mode into one multiply and an optional invert per channel, or a subtract clamped at zero.
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      op_next[c].x       = base_ch[c];
      op_next[c].y       = layer_ch[c];
      op_next[c].inv     = 1'b0;
      op_next[c].sub     = 1'b0;
      op_next[c].sub_res = (base_ch[c] > layer_ch[c]) ? base_ch[c] - layer_ch[c] : 8'd0;
      case (blend_mode)
        MODE_MULTIPLY: begin
        end
        MODE_SUBTRACT: begin
          op_next[c].sub = 1'b1;
        end
        MODE_SCREEN: begin
          op_next[c].x   = ~base_ch[c];
          op_next[c].y   = ~layer_ch[c];
          op_next[c].inv = 1'b1;
        end
        MODE_OVERLAY: begin
          if (!layer_ch[c][7]) begin
            op_next[c].y = {layer_ch[c][6:0], 1'b0};
          end else begin
            op_next[c].x   = ~base_ch[c];
            op_next[c].y   = {~layer_ch[c][6:0], 1'b0};
            op_next[c].inv = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_op   <= op_next;
      last[0] <= pix_in.pixel_last;
    end
    if (en[1]) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        s2_prod[c].prod    <= 16'(s1_op[c].x) * 16'(s1_op[c].y);
        s2_prod[c].inv     <= s1_op[c].inv;
        s2_prod[c].sub     <= s1_op[c].sub;
        s2_prod[c].sub_res <= s1_op[c].sub_res;
      end
      last[1] <= last[0];
    end
    if (en[2]) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        s3_quot[c].q <= 8'(((32'(s2_prod[c].prod) + 32'(ROUND_OFS)) * 32'(RECIP_255))
                            >> RECIP_SHIFT);
        s3_quot[c].inv     <= s2_prod[c].inv;
        s3_quot[c].sub     <= s2_prod[c].sub;
        s3_quot[c].sub_res <= s2_prod[c].sub_res;
      end
      last[2] <= last[1];
    end
    if (en[3]) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        if (s3_quot[c].sub) begin
          s4_res[c] <= s3_quot[c].sub_res;
        end else if (s3_quot[c].inv) begin
          s4_res[c] <= ~s3_quot[c].q;
        end else begin
          s4_res[c] <= s3_quot[c].q;
        end
      end
      last[3] <= last[2];
    end
  end

  assign pix_out.valid     = v[NUM_STAGES-1];
  assign pix_out.out_blue  = s4_res[0];
  assign pix_out.out_green = s4_res[1];
  assign pix_out.out_red   = s4_res[2];
  assign pix_out.out_last  = last[NUM_STAGES-1];

  a_reset_empty: assert property (@(posedge clk) rst |=> !pix_out.valid)
    else $error("output valid after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> v[0])
    else $error("accepted word lost at first stage");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (&v) && !pix_out.ready |-> !pix_in.ready)
    else $error("input taken while pipeline full and stalled");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && !pix_out.ready |=> pix_out.valid && $stable(s4_res[0])
      && $stable(last[NUM_STAGES-1]))
    else $error("stalled output word changed");

endmodule
